### src/segisect_pkg.sv
// shared types for the segment intersection pipeline
// no dependencies
package segisect_pkg;

  typedef struct packed {
    logic neg;
    logic zero;
  } segisect_sign_t;

  localparam int unsigned NumOrient = 4;

endpackage

### src/segisect_diff.sv
// first stage: coordinate differences and per-segment min/max
// depends on segisect_pkg
module segisect_diff #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] dx_i,
  input  logic signed [COORD_BITS-1:0] dy_i,
  output logic signed [COORD_BITS:0]   ux_o [segisect_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   uy_o [segisect_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   vx_o [segisect_pkg::NumOrient],
  output logic signed [COORD_BITS:0]   vy_o [segisect_pkg::NumOrient],
  output logic signed [COORD_BITS-1:0] s1min_o [2],
  output logic signed [COORD_BITS-1:0] s1max_o [2],
  output logic signed [COORD_BITS-1:0] s2min_o [2],
  output logic signed [COORD_BITS-1:0] s2max_o [2]
);
  import segisect_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;

  logic signed [DW-1:0] axe, aye, bxe, bye, cxe, cye, dxe, dye;
  logic signed [DW-1:0] ux_d [NumOrient];
  logic signed [DW-1:0] uy_d [NumOrient];
  logic signed [DW-1:0] vx_d [NumOrient];
  logic signed [DW-1:0] vy_d [NumOrient];
  logic signed [COORD_BITS-1:0] s1min_d [2];
  logic signed [COORD_BITS-1:0] s1max_d [2];
  logic signed [COORD_BITS-1:0] s2min_d [2];
  logic signed [COORD_BITS-1:0] s2max_d [2];
  logic signed [DW-1:0] ux_q [NumOrient];
  logic signed [DW-1:0] uy_q [NumOrient];
  logic signed [DW-1:0] vx_q [NumOrient];
  logic signed [DW-1:0] vy_q [NumOrient];
  logic signed [COORD_BITS-1:0] s1min_q [2];
  logic signed [COORD_BITS-1:0] s1max_q [2];
  logic signed [COORD_BITS-1:0] s2min_q [2];
  logic signed [COORD_BITS-1:0] s2max_q [2];

  assign axe = DW'(ax_i);
  assign aye = DW'(ay_i);
  assign bxe = DW'(bx_i);
  assign bye = DW'(by_i);
  assign cxe = DW'(cx_i);
  assign cye = DW'(cy_i);
  assign dxe = DW'(dx_i);
  assign dye = DW'(dy_i);

  always_comb begin
    // (a-c) x (d-c)
    ux_d[0] = axe - cxe;
    uy_d[0] = aye - cye;
    vx_d[0] = dxe - cxe;
    vy_d[0] = dye - cye;
    // (b-c) x (d-c)
    ux_d[1] = bxe - cxe;
    uy_d[1] = bye - cye;
    vx_d[1] = dxe - cxe;
    vy_d[1] = dye - cye;
    // (b-a) x (c-a)
    ux_d[2] = bxe - axe;
    uy_d[2] = bye - aye;
    vx_d[2] = cxe - axe;
    vy_d[2] = cye - aye;
    // (b-a) x (d-a)
    ux_d[3] = bxe - axe;
    uy_d[3] = bye - aye;
    vx_d[3] = dxe - axe;
    vy_d[3] = dye - aye;

    s1min_d[0] = (ax_i > bx_i) ? bx_i : ax_i;
    s1max_d[0] = (ax_i > bx_i) ? ax_i : bx_i;
    s1min_d[1] = (ay_i > by_i) ? by_i : ay_i;
    s1max_d[1] = (ay_i > by_i) ? ay_i : by_i;
    s2min_d[0] = (cx_i > dx_i) ? dx_i : cx_i;
    s2max_d[0] = (cx_i > dx_i) ? cx_i : dx_i;
    s2min_d[1] = (cy_i > dy_i) ? dy_i : cy_i;
    s2max_d[1] = (cy_i > dy_i) ? cy_i : dy_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ux_q    <= ux_d;
      uy_q    <= uy_d;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      s1min_q <= s1min_d;
      s1max_q <= s1max_d;
      s2min_q <= s2min_d;
      s2max_q <= s2max_d;
    end
  end

  assign ux_o    = ux_q;
  assign uy_o    = uy_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign s1min_o = s1min_q;
  assign s1max_o = s1max_q;
  assign s2min_o = s2min_q;
  assign s2max_o = s2max_q;

endmodule

### src/segisect_mul.sv
// second stage: cross product terms and bounding interval limits
// depends on segisect_pkg
module segisect_mul #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [COORD_BITS:0]        ux_i [segisect_pkg::NumOrient],
  input  logic signed [COORD_BITS:0]        uy_i [segisect_pkg::NumOrient],
  input  logic signed [COORD_BITS:0]        vx_i [segisect_pkg::NumOrient],
  input  logic signed [COORD_BITS:0]        vy_i [segisect_pkg::NumOrient],
  input  logic signed [COORD_BITS-1:0]      s1min_i [2],
  input  logic signed [COORD_BITS-1:0]      s1max_i [2],
  input  logic signed [COORD_BITS-1:0]      s2min_i [2],
  input  logic signed [COORD_BITS-1:0]      s2max_i [2],
  output logic signed [2*COORD_BITS+1:0]    pa_o [segisect_pkg::NumOrient],
  output logic signed [2*COORD_BITS+1:0]    pb_o [segisect_pkg::NumOrient],
  output logic signed [COORD_BITS-1:0]      lo_o [2],
  output logic signed [COORD_BITS-1:0]      hi_o [2]
);
  import segisect_pkg::*;

  localparam int unsigned PW = 2 * (COORD_BITS + 1);

  logic signed [PW-1:0]         pa_d [NumOrient];
  logic signed [PW-1:0]         pb_d [NumOrient];
  logic signed [PW-1:0]         pa_q [NumOrient];
  logic signed [PW-1:0]         pb_q [NumOrient];
  logic signed [COORD_BITS-1:0] lo_d [2];
  logic signed [COORD_BITS-1:0] hi_d [2];
  logic signed [COORD_BITS-1:0] lo_q [2];
  logic signed [COORD_BITS-1:0] hi_q [2];

  always_comb begin
    for (int k = 0; k < NumOrient; k++) begin
      pa_d[k] = PW'(ux_i[k]) * PW'(vy_i[k]);
      pb_d[k] = PW'(uy_i[k]) * PW'(vx_i[k]);
    end
    for (int j = 0; j < 2; j++) begin
      lo_d[j] = (s1min_i[j] > s2min_i[j]) ? s1min_i[j] : s2min_i[j];
      hi_d[j] = (s1max_i[j] < s2max_i[j]) ? s1max_i[j] : s2max_i[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign pa_o = pa_q;
  assign pb_o = pb_q;
  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

### src/segisect_sign.sv
// third stage: cross product difference, sign flags, interval overlap
// depends on segisect_pkg
module segisect_sign #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [2*COORD_BITS+1:0]      pa_i [segisect_pkg::NumOrient],
  input  logic signed [2*COORD_BITS+1:0]      pb_i [segisect_pkg::NumOrient],
  input  logic signed [COORD_BITS-1:0]        lo_i [2],
  input  logic signed [COORD_BITS-1:0]        hi_i [2],
  output segisect_pkg::segisect_sign_t        sgn_o [segisect_pkg::NumOrient],
  output logic                                span_ok_o
);
  import segisect_pkg::*;

  localparam int unsigned PW = 2 * (COORD_BITS + 1);
  localparam int unsigned OW = PW + 1;

  logic signed [OW-1:0] orient [NumOrient];
  segisect_sign_t       sgn_d [NumOrient];
  segisect_sign_t       sgn_q [NumOrient];
  logic                 span_ok_d;
  logic                 span_ok_q;

  always_comb begin
    for (int k = 0; k < NumOrient; k++) begin
      orient[k]    = OW'(pa_i[k]) - OW'(pb_i[k]);
      sgn_d[k].neg  = orient[k][OW-1];
      sgn_d[k].zero = (orient[k] == '0);
    end
    span_ok_d = (lo_i[0] <= hi_i[0]) && (lo_i[1] <= hi_i[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sgn_q     <= sgn_d;
      span_ok_q <= span_ok_d;
    end
  end

  assign sgn_o     = sgn_q;
  assign span_ok_o = span_ok_q;

endmodule

### src/segment_intersection_test.sv
// segment intersection test, top level: four pipeline stages
// throughput 1 request per cycle while the output side keeps ready_i high
// stages: differences, products, orientation signs, decision and output register
// each stage advances when empty or when the next stage advances
// reset clears all stage valid bits; data registers are not reset
// depends on segisect_pkg, segisect_diff, segisect_mul, segisect_sign
module segment_intersection_test #(
  parameter int unsigned COORD_BITS = 31
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic signed [COORD_BITS-1:0] dx_i,
  input  logic signed [COORD_BITS-1:0] dy_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic                         intersects_o
);
  import segisect_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;
  logic hit_d, hit_q;
  logic collinear, differ_ab, differ_cd;

  logic signed [DW-1:0]         ux [NumOrient];
  logic signed [DW-1:0]         uy [NumOrient];
  logic signed [DW-1:0]         vx [NumOrient];
  logic signed [DW-1:0]         vy [NumOrient];
  logic signed [COORD_BITS-1:0] s1min [2];
  logic signed [COORD_BITS-1:0] s1max [2];
  logic signed [COORD_BITS-1:0] s2min [2];
  logic signed [COORD_BITS-1:0] s2max [2];
  logic signed [PW-1:0]         pa [NumOrient];
  logic signed [PW-1:0]         pb [NumOrient];
  logic signed [COORD_BITS-1:0] lo [2];
  logic signed [COORD_BITS-1:0] hi [2];
  segisect_sign_t               sgn [NumOrient];
  logic                         span_ok;

  // stall chain
  assign eno     = !vo_q || ready_i;
  assign en3     = !v3_q || eno;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  segisect_diff #(
    .COORD_BITS(COORD_BITS)
  ) u_diff (
    .clk_i  (clk_i),
    .en_i   (en1 && valid_i),
    .ax_i   (ax_i),
    .ay_i   (ay_i),
    .bx_i   (bx_i),
    .by_i   (by_i),
    .cx_i   (cx_i),
    .cy_i   (cy_i),
    .dx_i   (dx_i),
    .dy_i   (dy_i),
    .ux_o   (ux),
    .uy_o   (uy),
    .vx_o   (vx),
    .vy_o   (vy),
    .s1min_o(s1min),
    .s1max_o(s1max),
    .s2min_o(s2min),
    .s2max_o(s2max)
  );

  segisect_mul #(
    .COORD_BITS(COORD_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (en2 && v1_q),
    .ux_i   (ux),
    .uy_i   (uy),
    .vx_i   (vx),
    .vy_i   (vy),
    .s1min_i(s1min),
    .s1max_i(s1max),
    .s2min_i(s2min),
    .s2max_i(s2max),
    .pa_o   (pa),
    .pb_o   (pb),
    .lo_o   (lo),
    .hi_o   (hi)
  );

  segisect_sign #(
    .COORD_BITS(COORD_BITS)
  ) u_sign (
    .clk_i    (clk_i),
    .en_i     (en3 && v2_q),
    .pa_i     (pa),
    .pb_i     (pb),
    .lo_i     (lo),
    .hi_i     (hi),
    .sgn_o    (sgn),
    .span_ok_o(span_ok)
  );

  // (d-c)x(a-c) and (d-c)x(b-c) are the negated first two cross products
  assign collinear = sgn[0].zero && sgn[1].zero;
  assign differ_cd = (sgn[0].neg != sgn[1].neg) || (sgn[0].zero != sgn[1].zero);
  assign differ_ab = (sgn[2].neg != sgn[3].neg) || (sgn[2].zero != sgn[3].zero);
  assign hit_d     = collinear ? span_ok : (differ_ab && differ_cd);

  always_ff @(posedge clk_i) begin
    if (eno && v3_q) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o      = vo_q;
  assign intersects_o = hit_q;

endmodule

### tb/sv/segment_intersection_test_tb.sv
// testbench for segment_intersection_test: directed and random segment pairs,
// random idling on both handshakes, predicted hit compared per result
// depends only on the segment_intersection_test rtl
module segment_intersection_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 31;
  localparam int COORD_MIN = -(1 << 30);
  localparam int COORD_MAX = (1 << 30) - 1;
  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct {
    seg_pair_t pair;
    bit        hit;
  } hit_expect_t;

  class hit_scoreboard;
    hit_expect_t hit_expected[$];
    int unsigned checked;
    int unsigned hits;
    int unsigned mismatches;

    static function longint cross3(longint ox, longint oy, longint px, longint py,
                                   longint qx, longint qy);
      return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
    endfunction

    static function int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    static function bit spans_meet(longint p, longint q, longint r, longint s);
      longint t;
      if (p > q) begin
        t = p; p = q; q = t;
      end
      if (r > s) begin
        t = r; r = s; s = t;
      end
      return ((p > r) ? p : r) <= ((q < s) ? q : s);
    endfunction

    static function bit segments_touch(seg_pair_t s);
      longint ax, ay, bx, by, cx, cy, dx, dy;
      ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
      cx = s.cx; cy = s.cy; dx = s.dx; dy = s.dy;
      if (cross3(cx, cy, ax, ay, dx, dy) == 0 && cross3(cx, cy, bx, by, dx, dy) == 0)
        return spans_meet(ax, bx, cx, dx) && spans_meet(ay, by, cy, dy);
      return sign_of(cross3(ax, ay, bx, by, cx, cy)) !=
             sign_of(cross3(ax, ay, bx, by, dx, dy)) &&
             sign_of(cross3(cx, cy, dx, dy, ax, ay)) !=
             sign_of(cross3(cx, cy, dx, dy, bx, by));
    endfunction

    function void note_request(seg_pair_t s);
      hit_expect_t e;
      e.pair = s;
      e.hit = segments_touch(s);
      hit_expected.push_back(e);
    endfunction

    function void check_result(bit got);
      hit_expect_t e;
      if (hit_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected (got %0b)", checked, got);
      end else begin
        e = hit_expected.pop_front();
        if (e.hit)
          hits++;
        if (got !== e.hit) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on result %0d: A(%0d,%0d) B(%0d,%0d) C(%0d,%0d) D(%0d,%0d) expected %0b got %0b",
                     checked, e.pair.ax, e.pair.ay, e.pair.bx, e.pair.by,
                     e.pair.cx, e.pair.cy, e.pair.dx, e.pair.dy, e.hit, got);
        end
      end
      checked++;
    endfunction

    function int unsigned pending();
      return hit_expected.size();
    endfunction

    function bit clean();
      return mismatches == 0 && hit_expected.size() == 0;
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   valid_i = 1'b0;
  logic   ready_o;
  coord_t ax_i = '0;
  coord_t ay_i = '0;
  coord_t bx_i = '0;
  coord_t by_i = '0;
  coord_t cx_i = '0;
  coord_t cy_i = '0;
  coord_t dx_i = '0;
  coord_t dy_i = '0;
  logic   valid_o;
  logic   ready_i = 1'b0;
  logic   intersects_o;

  hit_scoreboard sb = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned cycle_count = 0;

  segment_intersection_test #(
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .ready_o     (ready_o),
    .ax_i        (ax_i),
    .ay_i        (ay_i),
    .bx_i        (bx_i),
    .by_i        (by_i),
    .cx_i        (cx_i),
    .cy_i        (cy_i),
    .dx_i        (dx_i),
    .dy_i        (dy_i),
    .valid_o     (valid_o),
    .ready_i     (ready_i),
    .intersects_o(intersects_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("segment_intersection_test verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rx_steady) ready_i <= 1'b1;
    else ready_i <= ($urandom_range(99) >= 7);
  end

  // inputs only change at rising edges, so the falling edge sees settled handshakes
  always @(negedge clk_i) begin : monitor
    seg_pair_t seen;
    if (rst_ni) begin
      if (valid_i && ready_o) begin
        seen.ax = ax_i; seen.ay = ay_i; seen.bx = bx_i; seen.by = by_i;
        seen.cx = cx_i; seen.cy = cy_i; seen.dx = dx_i; seen.dy = dy_i;
        sb.note_request(seen);
      end
      if (valid_o && ready_i)
        sb.check_result(intersects_o);
    end
  end

  function automatic seg_pair_t pair_of(int ax, int ay, int bx, int by,
                                        int cx, int cy, int dx, int dy);
    seg_pair_t s;
    s.ax = coord_t'(ax); s.ay = coord_t'(ay); s.bx = coord_t'(bx); s.by = coord_t'(by);
    s.cx = coord_t'(cx); s.cy = coord_t'(cy); s.dx = coord_t'(dx); s.dy = coord_t'(dy);
    return s;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(5))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  function automatic int small_coord();
    return int'($urandom_range(16)) - 8;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t s;
    int px, py, vx, vy, t0, t1, t2, t3, n;
    case ($urandom_range(9))
      0, 1, 2: begin
        s.ax = coord_t'($urandom); s.ay = coord_t'($urandom);
        s.bx = coord_t'($urandom); s.by = coord_t'($urandom);
        s.cx = coord_t'($urandom); s.cy = coord_t'($urandom);
        s.dx = coord_t'($urandom); s.dy = coord_t'($urandom);
      end
      3, 4: s = pair_of(small_coord(), small_coord(), small_coord(), small_coord(),
                        small_coord(), small_coord(), small_coord(), small_coord());
      5: begin
        // all four points on one line
        px = spread(1 << 28); py = spread(1 << 28);
        vx = spread(1 << 10); vy = spread(1 << 10);
        t0 = spread(1 << 10); t1 = spread(1 << 10);
        t2 = spread(1 << 10); t3 = spread(1 << 10);
        s = pair_of(px + t0 * vx, py + t0 * vy, px + t1 * vx, py + t1 * vy,
                    px + t2 * vx, py + t2 * vy, px + t3 * vx, py + t3 * vy);
      end
      6: begin
        s = pair_of(spread(1 << 29), spread(1 << 29), spread(1 << 29), spread(1 << 29),
                    spread(1 << 29), spread(1 << 29), spread(1 << 29), spread(1 << 29));
        case ($urandom_range(3))
          0: begin s.cx = s.ax; s.cy = s.ay; end
          1: begin s.dx = s.ax; s.dy = s.ay; end
          2: begin s.cx = s.bx; s.cy = s.by; end
          default: begin s.dx = s.bx; s.dy = s.by; end
        endcase
      end
      7, 9: begin
        // point of one segment placed on the other, or near it
        px = spread(1 << 28); py = spread(1 << 28);
        vx = spread(1 << 14); vy = spread(1 << 14);
        n = int'($urandom_range(1, 8));
        t0 = int'($urandom_range(n));
        s = pair_of(px, py, px + n * vx, py + n * vy,
                    px + t0 * vx + spread(1), py + t0 * vy + spread(1), 0, 0);
        if ($urandom_range(1)) begin
          s.dx = s.cx; s.dy = s.cy;
        end else begin
          s.dx = coord_t'(spread(1 << 29)); s.dy = coord_t'(spread(1 << 29));
        end
        if ($urandom_range(1))
          s = pair_of(s.cx, s.cy, s.dx, s.dy, s.ax, s.ay, s.bx, s.by);
      end
      default: s = pair_of(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                           extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    endcase
    return s;
  endfunction

  // caller sits just after a rising edge
  task automatic send_pair(input seg_pair_t s);
    while (!tx_steady && $urandom_range(99) < 7) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    ax_i <= s.ax; ay_i <= s.ay; bx_i <= s.bx; by_i <= s.by;
    cx_i <= s.cx; cy_i <= s.cy; dx_i <= s.dx; dy_i <= s.dy;
    do @(negedge clk_i); while (!ready_o);
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin
    seg_pair_t directed[$];
    int unsigned n;
    directed.push_back(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    directed.push_back(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                               COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    directed.push_back(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                               COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
    directed.push_back(pair_of(COORD_MIN, 0, COORD_MAX, 0, 0, COORD_MIN, 0, COORD_MAX));
    directed.push_back(pair_of(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                               COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
    directed.push_back(pair_of(-1, -1, 1, 1, -1, 1, 1, -1));
    directed.push_back(pair_of(0, 0, 10, 0, 0, 5, 10, 5));
    directed.push_back(pair_of(0, 0, 10, 10, 5, 5, 20, 20));
    directed.push_back(pair_of(0, 0, 5, 5, 5, 5, 9, 9));
    directed.push_back(pair_of(0, 0, 4, 4, 5, 5, 9, 9));
    directed.push_back(pair_of(3, 0, 3, 10, 3, 12, 3, 6));
    directed.push_back(pair_of(COORD_MIN, COORD_MIN, -1, -1, 0, 0, COORD_MAX, COORD_MAX));
    directed.push_back(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
    directed.push_back(pair_of(0, 0, 10, 0, 10, 0, 10, 10));
    directed.push_back(pair_of(0, 0, 10, 0, 11, -5, 11, 5));
    // second segment a single point: on, inside the bounding box, outside it
    directed.push_back(pair_of(0, 0, 10, 10, 4, 4, 4, 4));
    directed.push_back(pair_of(0, 0, 10, 10, 2, 6, 2, 6));
    directed.push_back(pair_of(0, 0, 10, 10, 20, 20, 20, 20));
    directed.push_back(pair_of(5, 5, 5, 5, 0, 0, 10, 10));
    directed.push_back(pair_of(5, 0, 5, 0, 0, 0, 10, 10));
    directed.push_back(pair_of(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                               COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i])
      send_pair(directed[i]);
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      tx_steady = (n >= 700 && n < 1100);
      rx_steady = tx_steady;
      if (n == 1300)
        drain_results();
      send_pair(random_pair());
    end
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("%0d segment pairs checked (%0d intersecting, %0d apart) in %0d cycles",
             sb.checked, sb.hits, sb.checked - sb.hits, cycle_count);
    $display("mix: extremes, collinear runs, shared endpoints, point segments, %0d mismatches",
             sb.mismatches);
    if (sb.clean()) begin
      $display("segment_intersection_test verification clean");
    end else begin
      $display("segment_intersection_test verification failed");
    end
    $finish;
  end

endmodule
